@@ design/binc_pkg.sv @@
// ----------------------------------------------------------------------------
// binc_pkg
// Shared types, command codes and code-bit mapping for the bitmap store.
// ----------------------------------------------------------------------------
package binc_pkg;

  typedef enum logic [2:0] {
    CMD_SET        = 3'd0,
    CMD_CLEAR      = 3'd1,
    CMD_READ       = 3'd2,
    CMD_NEXT_SET   = 3'd3,
    CMD_NEXT_SET_IN = 3'd4,
    CMD_NEXT_CLR_IN = 3'd5
  } cmd_t;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_START,
    ST_PWAIT,
    ST_PUSE,
    ST_NB,
    ST_NWAIT,
    ST_NRMW,
    ST_DIV,
    ST_SADDR,
    ST_SWAIT,
    ST_SCHK,
    ST_DONE
  } state_t;

  localparam int unsigned CODE_W = 48;

  // Radius 1 layout: E,NE,N,NW,W,SW,S,SE in bits 0..7, indexed by window position
  localparam logic [2:0] R1_BIT [9] = '{3'd3, 3'd2, 3'd1, 3'd4, 3'd0, 3'd0, 3'd5, 3'd6, 3'd7};

  // Bit that a pixel at window offset (i,j) (0..2*rad) holds in the owner's code
  function automatic logic [5:0] code_bit(input logic [2:0] i, input logic [2:0] j,
                                          input logic [1:0] rad);
    logic [5:0] k;
    logic [5:0] p;
    logic [5:0] mid;
    k   = {3'b0, rad, 1'b1};
    p   = 6'(6'(i) * k + 6'(j));
    mid = 6'((k * k) >> 1);
    if (rad == 2'd1) begin
      code_bit = {3'b0, R1_BIT[4'(4'(i) * 4'd3 + 4'(j))]};
    end else if (p > mid) begin
      code_bit = p - 6'd1;
    end else begin
      code_bit = p;
    end
  endfunction

endpackage

@@ design/binary_image_neighbour_code_store.sv @@
// ----------------------------------------------------------------------------
// binary_image_neighbour_code_store
// Bitmap with per-pixel neighbour codes, set count and three scan iterators.
// ----------------------------------------------------------------------------
// Operation: set/clear visits every window position and updates the code of
//   each in-image neighbour; a scan divides, then checks pixels one by one.
// Throughput: one request at a time; in_tready is high only between requests.
// Reset: synchronous; a clearing pass over MAX_ROWS*MAX_COLS entries (rounded
//   up to powers of two, at most 16384) zeroes the bitmap and codes first.
module binary_image_neighbour_code_store
  import binc_pkg::*;
#(
  parameter int MAX_ROWS = 128,
  parameter int MAX_COLS = 128
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [2:0] command, [9:3] row, [16:10] col, [19:17] kernel_size, [23:20] zero
  input  logic [23:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [0] status, [1] pixel, [49:2] neighbour_code, [50] found,
  // [57:51] found_row, [64:58] found_col, [79:65] set_count
  output logic [79:0] out_tdata,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [7:0]  cfg_wdata
);

  localparam int RU = (MAX_ROWS < 128) ? MAX_ROWS : 128;
  localparam int CU = (MAX_COLS < 128) ? MAX_COLS : 128;
  localparam int RW = $clog2(RU);
  localparam int CW = $clog2(CU);
  localparam int AW = RW + CW;
  localparam int DEPTH = 1 << AW;
  localparam logic [7:0] RU8 = 8'(RU);
  localparam logic [7:0] CU8 = 8'(CU);

  // configuration
  logic [1:0] radius_r;
  logic [7:0] rows_cfg_r, cols_cfg_r;
  logic [7:0] rows_eff, cols_eff;
  logic [15:0] total_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      radius_r   <= 2'd1;
      rows_cfg_r <= 8'd128;
      cols_cfg_r <= 8'd128;
    end else if (cfg_we) begin
      case (cfg_index)
        2'd0:    radius_r   <= cfg_wdata[1:0];
        2'd1:    rows_cfg_r <= cfg_wdata;
        2'd2:    cols_cfg_r <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign rows_eff = (rows_cfg_r > RU8) ? RU8 : rows_cfg_r;
  assign cols_eff = (cols_cfg_r > CU8) ? CU8 : cols_cfg_r;

  always_ff @(posedge clk) total_r <= 16'(rows_eff) * 16'(cols_eff);

  // state
  state_t state_r, state_nxt;
  logic [AW-1:0] clr_cnt_r, clr_cnt_nxt;
  cmd_t    cmd_r, cmd_nxt;
  logic [6:0]  row_r, row_nxt, col_r, col_nxt;
  logic [1:0]  half_r, half_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [2:0]  ni_r, ni_nxt, nj_r, nj_nxt;
  logic [14:0] p_r, p_nxt, dq_r, dq_nxt;
  logic [6:0]  rem_r, rem_nxt;
  logic [3:0]  dcnt_r, dcnt_nxt;
  logic [14:0] pos_r [3];
  logic [14:0] pos_nxt [3];
  logic [14:0] total_cnt_r, total_cnt_nxt;
  logic        res_status_r, res_status_nxt, res_pixel_r, res_pixel_nxt;
  logic [47:0] res_code_r, res_code_nxt;
  logic        res_found_r, res_found_nxt;
  logic [6:0]  res_frow_r, res_frow_nxt, res_fcol_r, res_fcol_nxt;
  logic        out_valid_r;
  logic [79:0] out_data_r;

  // memories
  logic          pix_mem [DEPTH];
  logic [47:0]   code_mem [DEPTH];
  logic          pix_q;
  logic [47:0]   code_q;
  logic          pix_we, code_we, pix_wd;
  logic [47:0]   code_wd;
  logic [AW-1:0] waddr;

  always_ff @(posedge clk) begin
    if (pix_we) pix_mem[waddr] <= pix_wd;
    if (code_we) code_mem[waddr] <= code_wd;
    pix_q  <= pix_mem[addr_r];
    code_q <= code_mem[addr_r];
  end

  // request fields
  logic [2:0] in_cmd;
  logic [6:0] in_row, in_col;
  logic [2:0] in_ks;
  assign in_cmd = in_tdata[2:0];
  assign in_row = in_tdata[9:3];
  assign in_col = in_tdata[16:10];
  assign in_ks  = in_tdata[19:17];

  assign in_tready = (state_r == ST_IDLE);
  logic accept;
  assign accept = in_tvalid && in_tready;

  // shared helpers
  logic [1:0]  scan_it;
  logic        outside;
  logic [2:0]  span;
  logic        nb_last, nb_center, nb_out;
  logic signed [9:0] qr, qc;
  logic [7:0]  rem_sh;
  logic        div_ge;
  logic        scan_v, scan_inside, scan_hit, scan_end;
  logic [47:0] nb_bit;

  assign scan_it = 2'(cmd_r - CMD_NEXT_SET);
  assign outside = ({1'b0, row_r} >= rows_eff) || ({1'b0, col_r} >= cols_eff);
  assign span = {radius_r, 1'b0};
  assign nb_last = (ni_r == span) && (nj_r == span);
  assign nb_center = (ni_r == {1'b0, radius_r}) && (nj_r == {1'b0, radius_r});
  assign qr = $signed({3'b0, row_r}) + $signed({7'b0, ni_r}) - $signed({8'b0, radius_r});
  assign qc = $signed({3'b0, col_r}) + $signed({7'b0, nj_r}) - $signed({8'b0, radius_r});
  assign nb_out = (qr < 0) || (qc < 0) || (qr >= $signed({2'b0, rows_eff}))
               || (qc >= $signed({2'b0, cols_eff}));
  assign nb_bit = 48'(1) << code_bit(ni_r, nj_r, radius_r);
  assign rem_sh = {rem_r, dq_r[14]};
  assign div_ge = rem_sh >= cols_eff;
  assign scan_v = pix_q ^ (cmd_r == CMD_NEXT_CLR_IN);
  assign scan_inside = (row_r >= 7'(half_r)) && (col_r >= 7'(half_r))
                    && (8'(row_r) + 8'(half_r) < rows_eff)
                    && (8'(col_r) + 8'(half_r) < cols_eff);
  assign scan_hit = scan_v && ((cmd_r == CMD_NEXT_SET) || scan_inside);
  assign scan_end = 16'(p_r) + 16'd1 >= total_r;

  logic out_free;
  assign out_free = !out_valid_r || out_tready;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: if (clr_cnt_r == AW'(DEPTH - 1)) state_nxt = ST_IDLE;
      ST_IDLE:  if (accept) state_nxt = ST_START;
      ST_START: begin
        if (cmd_r inside {CMD_SET, CMD_CLEAR, CMD_READ}) begin
          state_nxt = outside ? ST_DONE : ST_PWAIT;
        end else if (cmd_r inside {CMD_NEXT_SET, CMD_NEXT_SET_IN, CMD_NEXT_CLR_IN}) begin
          state_nxt = (16'(pos_r[scan_it]) >= total_r) ? ST_DONE : ST_DIV;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_PWAIT: state_nxt = ST_PUSE;
      ST_PUSE:  state_nxt = (cmd_r == CMD_READ) ? ST_DONE : ST_NB;
      ST_NB: begin
        if (!nb_center && !nb_out) state_nxt = ST_NWAIT;
        else if (nb_last) state_nxt = ST_DONE;
      end
      ST_NWAIT: state_nxt = ST_NRMW;
      ST_NRMW:  state_nxt = nb_last ? ST_DONE : ST_NB;
      ST_DIV:   if (dcnt_r == 4'd14) state_nxt = ST_SADDR;
      ST_SADDR: state_nxt = ST_SWAIT;
      ST_SWAIT: state_nxt = ST_SCHK;
      ST_SCHK:  state_nxt = (scan_hit || scan_end) ? ST_DONE : ST_SWAIT;
      ST_DONE:  if (out_free) state_nxt = ST_IDLE;
      default:  state_nxt = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    clr_cnt_nxt = clr_cnt_r;
    cmd_nxt = cmd_r;
    row_nxt = row_r;
    col_nxt = col_r;
    half_nxt = half_r;
    addr_nxt = addr_r;
    ni_nxt = ni_r;
    nj_nxt = nj_r;
    p_nxt = p_r;
    dq_nxt = dq_r;
    rem_nxt = rem_r;
    dcnt_nxt = dcnt_r;
    pos_nxt = pos_r;
    total_cnt_nxt = total_cnt_r;
    res_status_nxt = res_status_r;
    res_pixel_nxt = res_pixel_r;
    res_code_nxt = res_code_r;
    res_found_nxt = res_found_r;
    res_frow_nxt = res_frow_r;
    res_fcol_nxt = res_fcol_r;
    pix_we = 1'b0;
    code_we = 1'b0;
    pix_wd = 1'b0;
    code_wd = '0;
    waddr = addr_r;
    case (state_r)
      ST_CLEAR: begin
        pix_we = 1'b1;
        code_we = 1'b1;
        waddr = clr_cnt_r;
        clr_cnt_nxt = clr_cnt_r + AW'(1);
      end
      ST_IDLE: if (accept) begin
        cmd_nxt = cmd_t'(in_cmd);
        row_nxt = in_row;
        col_nxt = in_col;
        half_nxt = in_ks[2:1];
      end
      ST_START: begin
        res_status_nxt = 1'b0;
        res_pixel_nxt = 1'b0;
        res_code_nxt = '0;
        res_found_nxt = 1'b0;
        res_frow_nxt = '0;
        res_fcol_nxt = '0;
        addr_nxt = {row_r[RW-1:0], col_r[CW-1:0]};
        p_nxt = pos_r[scan_it];
        dq_nxt = pos_r[scan_it];
        rem_nxt = '0;
        dcnt_nxt = '0;
        if (cmd_r inside {CMD_SET, CMD_CLEAR, CMD_READ}) begin
          res_status_nxt = outside;
        end else if (cmd_r inside {CMD_NEXT_SET, CMD_NEXT_SET_IN, CMD_NEXT_CLR_IN}) begin
          if (16'(pos_r[scan_it]) >= total_r) pos_nxt[scan_it] = '0;
        end
      end
      ST_PUSE: begin
        ni_nxt = '0;
        nj_nxt = '0;
        if (cmd_r == CMD_READ) begin
          res_pixel_nxt = pix_q;
          res_code_nxt = (radius_r != 2'd0) ? code_q : '0;
        end else begin
          pix_we = 1'b1;
          pix_wd = (cmd_r == CMD_SET);
          if (cmd_r == CMD_SET && !pix_q) total_cnt_nxt = total_cnt_r + 15'd1;
          if (cmd_r == CMD_CLEAR && pix_q) total_cnt_nxt = total_cnt_r - 15'd1;
        end
      end
      ST_NB: begin
        if (!nb_center && !nb_out) begin
          addr_nxt = {qr[RW-1:0], qc[CW-1:0]};
        end else if (nj_r == span) begin
          nj_nxt = '0;
          ni_nxt = ni_r + 3'd1;
        end else begin
          nj_nxt = nj_r + 3'd1;
        end
      end
      ST_NRMW: begin
        code_we = 1'b1;
        code_wd = (cmd_r == CMD_SET) ? (code_q | nb_bit) : (code_q & ~nb_bit);
        if (nj_r == span) begin
          nj_nxt = '0;
          ni_nxt = ni_r + 3'd1;
        end else begin
          nj_nxt = nj_r + 3'd1;
        end
      end
      ST_DIV: begin
        // one restoring step per cycle: position -> row, col
        rem_nxt = div_ge ? 7'(rem_sh - cols_eff) : rem_sh[6:0];
        dq_nxt = {dq_r[13:0], div_ge};
        dcnt_nxt = dcnt_r + 4'd1;
      end
      ST_SADDR: begin
        row_nxt = dq_r[6:0];
        col_nxt = rem_r;
        addr_nxt = {dq_r[RW-1:0], rem_r[CW-1:0]};
      end
      ST_SCHK: begin
        if (scan_hit) begin
          pos_nxt[scan_it] = p_r + 15'd1;
          res_found_nxt = 1'b1;
          res_frow_nxt = row_r;
          res_fcol_nxt = col_r;
        end else if (scan_end) begin
          pos_nxt[scan_it] = '0;
        end else begin
          // advance one pixel in row-major order
          p_nxt = p_r + 15'd1;
          if (8'(col_r) + 8'd1 == cols_eff) begin
            col_nxt = '0;
            row_nxt = row_r + 7'd1;
            addr_nxt = {RW'(row_r + 7'd1), CW'(0)};
          end else begin
            col_nxt = col_r + 7'd1;
            addr_nxt = {row_r[RW-1:0], CW'(col_r + 7'd1)};
          end
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
      clr_cnt_r <= '0;
      total_cnt_r <= '0;
      pos_r <= '{default: '0};
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      clr_cnt_r <= clr_cnt_nxt;
      total_cnt_r <= total_cnt_nxt;
      pos_r <= pos_nxt;
      if (state_r == ST_DONE && out_free) out_valid_r <= 1'b1;
      else if (out_tready) out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    cmd_r <= cmd_nxt;
    row_r <= row_nxt;
    col_r <= col_nxt;
    half_r <= half_nxt;
    addr_r <= addr_nxt;
    ni_r <= ni_nxt;
    nj_r <= nj_nxt;
    p_r <= p_nxt;
    dq_r <= dq_nxt;
    rem_r <= rem_nxt;
    dcnt_r <= dcnt_nxt;
    res_status_r <= res_status_nxt;
    res_pixel_r <= res_pixel_nxt;
    res_code_r <= res_code_nxt;
    res_found_r <= res_found_nxt;
    res_frow_r <= res_frow_nxt;
    res_fcol_r <= res_fcol_nxt;
    if (state_r == ST_DONE && out_free) begin
      out_data_r <= {total_cnt_r, res_fcol_r, res_frow_r, res_found_r,
                     res_code_r, res_pixel_r, res_status_r};
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !in_tready) else $error("request taken during clear pass");
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    total_cnt_r <= 15'(DEPTH)) else $error("set count beyond store size");
  a_rmw_order: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_NRMW) |-> $past(state_r) == ST_NWAIT) else $error("code write without read");
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    res_found_r |-> !res_status_r) else $error("found with error status");

endmodule
